[sv/agpc_pkg.sv]
// ============================================================================
// agpc_pkg
// Shared types and constants for the alpha glyph pixel compositor.
// ============================================================================
package agpc_pkg;

    // Widths fixed by the pixel format and the register map
    localparam int PIX_W   = 24;
    localparam int ALPHA_W = 4;
    localparam int WEIGHT_W = 5;
    localparam int CFG_IDX_W = 3;

    // Packed channel masks
    localparam logic [PIX_W-1:0] RB_MASK = 24'hff00ff;
    localparam logic [PIX_W-1:0] G_MASK  = 24'h00ff00;
    localparam logic [ALPHA_W-1:0] ALPHA_MAX = 4'd15;

    // Register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_DRAW_MODE       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERSE_VIDEO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKDROP_ENABLE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ENABLE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FORE_COLOR      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BACK_COLOR      = 3'd5;

    // Draw modes
    typedef enum logic [1:0] {
        MODE_COMPLEMENT = 2'd0,
        MODE_BACK       = 2'd1,
        MODE_FORE       = 2'd2,
        MODE_SOLID      = 2'd3
    } t_mode;

    // Register file contents
    typedef struct packed {
        t_mode            draw_mode;
        logic             inverse_video;
        logic             backdrop_enable;
        logic             image_enable;
        logic [PIX_W-1:0] fore_color;
        logic [PIX_W-1:0] back_color;
    } t_cfg;

    // Stage 1 result: the two colors to mix and the weight
    typedef struct packed {
        logic [PIX_W-1:0]    c1;
        logic [PIX_W-1:0]    c2;
        logic [PIX_W-1:0]    px;
        logic [WEIGHT_W-1:0] w;
        logic                bypass;
    } t_sel;

    // Stage 2 result: scaled differences and base terms
    typedef struct packed {
        logic [PIX_W-1:0] rb_term;
        logic [PIX_W-1:0] g_term;
        logic [PIX_W-1:0] rb_base;
        logic [PIX_W-1:0] g_base;
        logic [PIX_W-1:0] px;
        logic             bypass;
    } t_prod;

endpackage

[sv/alpha_glyph_pixel_compositor.sv]
// ============================================================================
// alpha_glyph_pixel_compositor
// Per-pixel alpha blend of frame, backdrop, image and fixed colors.
// ============================================================================
// Usage:
//   Input channel: i_valid with i_alpha and the three pixels; the block
//   drives o_stall. A beat is taken when i_valid is high and o_stall low.
//   Output channel: o_valid with o_new_pixel; the receiver drives i_stall.
//   Pipeline stages: select, scale (one 32x5 multiply per packed channel
//   pair), merge into the output register.
//   Throughput is one pixel per cycle; each stage moves when it is empty or
//   the stage after it moves, so bubbles are squeezed out under stall.
//   When i_stall is held, the output beat stays put and the three stages
//   fill; o_stall rises only once all three hold a pixel.
//   Reset clears all stage valids and loads the register defaults: solid
//   mode, no inversion, no backdrop, no image, black foreground, white
//   background. Configuration writes take effect at once and are meant to
//   be made while the pipeline is empty.
// ============================================================================
module alpha_glyph_pixel_compositor
    import agpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [ALPHA_W-1:0]   i_alpha,
    input  logic [PIX_W-1:0]     i_frame_pixel,
    input  logic [PIX_W-1:0]     i_backdrop_pixel,
    input  logic [PIX_W-1:0]     i_image_pixel,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [PIX_W-1:0]     o_new_pixel
);

    t_cfg  r_cfg;
    logic  s1_valid;
    logic  s2_valid;
    t_sel  s1_sel;
    t_prod s2_prod;
    logic  en1;
    logic  en2;
    logic  en3;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.draw_mode       <= MODE_SOLID;
            r_cfg.inverse_video   <= 1'b0;
            r_cfg.backdrop_enable <= 1'b0;
            r_cfg.image_enable    <= 1'b0;
            r_cfg.fore_color      <= '0;
            r_cfg.back_color      <= '1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DRAW_MODE:       r_cfg.draw_mode       <= t_mode'(i_cfg_data[1:0]);
                CFG_INVERSE_VIDEO:   r_cfg.inverse_video   <= i_cfg_data[0];
                CFG_BACKDROP_ENABLE: r_cfg.backdrop_enable <= i_cfg_data[0];
                CFG_IMAGE_ENABLE:    r_cfg.image_enable    <= i_cfg_data[0];
                CFG_FORE_COLOR:      r_cfg.fore_color      <= i_cfg_data;
                CFG_BACK_COLOR:      r_cfg.back_color      <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Advance each stage when it is empty or the next one advances
    assign en3     = !o_valid || !i_stall;
    assign en2     = !s2_valid || en3;
    assign en1     = !s1_valid || en2;
    assign o_stall = !en1;

    agpc_select u_select (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en1),
        .i_valid          (i_valid),
        .i_cfg            (r_cfg),
        .i_alpha          (i_alpha),
        .i_frame_pixel    (i_frame_pixel),
        .i_backdrop_pixel (i_backdrop_pixel),
        .i_image_pixel    (i_image_pixel),
        .o_valid          (s1_valid),
        .o_sel            (s1_sel)
    );

    agpc_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en2),
        .i_valid (s1_valid),
        .i_sel   (s1_sel),
        .o_valid (s2_valid),
        .o_prod  (s2_prod)
    );

    agpc_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en3),
        .i_valid (s2_valid),
        .i_prod  (s2_prod),
        .o_valid (o_valid),
        .o_pixel (o_new_pixel)
    );

    // Back-pressure only when every stage holds a pixel
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (s1_valid && s2_valid && o_valid && i_stall))
        else $error("input stalled while pipeline has room");

    // A full pipeline under output stall must push back
    a_full_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_valid && s2_valid && o_valid && i_stall) |-> o_stall)
        else $error("full pipeline failed to stall input");

    // An accepted beat lands in stage one
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> s1_valid)
        else $error("accepted beat lost at stage one");

    // A stalled stage-two beat stays in stage two
    a_s2_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_valid && !en2) |=> (s2_valid && $stable(s2_prod)))
        else $error("stage two beat lost under stall");

endmodule

[sv/agpc_select.sv]
// ============================================================================
// agpc_select
// Stage 1: pick the two source colors and the blend weight per draw mode.
// ============================================================================
module agpc_select
    import agpc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  t_cfg                i_cfg,
    input  logic [ALPHA_W-1:0]  i_alpha,
    input  logic [PIX_W-1:0]    i_frame_pixel,
    input  logic [PIX_W-1:0]    i_backdrop_pixel,
    input  logic [PIX_W-1:0]    i_image_pixel,
    output logic                o_valid,
    output t_sel                o_sel
);

    logic               r_valid;
    t_sel               r_sel;
    t_sel               n_sel;
    logic [ALPHA_W-1:0] a_eff;
    logic               use_bd;
    logic [PIX_W-1:0]   back_src;
    logic [PIX_W-1:0]   fore_src;

    // Widen alpha to 0..16 after optional inversion
    always_comb begin
        a_eff    = i_cfg.inverse_video ? (ALPHA_MAX - i_alpha) : i_alpha;
        use_bd   = i_cfg.backdrop_enable & i_cfg.draw_mode[0];
        back_src = use_bd ? i_backdrop_pixel : i_cfg.back_color;
        fore_src = i_cfg.image_enable ? i_image_pixel : i_cfg.fore_color;

        n_sel.px     = i_frame_pixel;
        n_sel.w      = {1'b0, a_eff} + {{(WEIGHT_W-1){1'b0}}, a_eff[ALPHA_W-1]};
        n_sel.c1     = i_frame_pixel;
        n_sel.c2     = i_frame_pixel;
        n_sel.bypass = 1'b0;
        unique case (i_cfg.draw_mode)
            MODE_COMPLEMENT: begin
                n_sel.c1     = i_frame_pixel;
                n_sel.c2     = ~i_frame_pixel;
                n_sel.bypass = i_cfg.image_enable;
            end
            MODE_BACK: begin
                n_sel.c1     = back_src;
                n_sel.c2     = i_frame_pixel;
                n_sel.bypass = i_cfg.image_enable;
            end
            MODE_FORE: begin
                n_sel.c1 = i_frame_pixel;
                n_sel.c2 = fore_src;
            end
            MODE_SOLID: begin
                n_sel.c1 = back_src;
                n_sel.c2 = fore_src;
            end
            default: begin
                n_sel.c1 = i_frame_pixel;
                n_sel.c2 = i_frame_pixel;
            end
        endcase
    end

    // Advance stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload unless advancing
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sel <= n_sel;
        end
    end

    assign o_valid = r_valid;
    assign o_sel   = r_sel;

endmodule

[sv/agpc_scale.sv]
// ============================================================================
// agpc_scale
// Stage 2: packed difference times weight for red/blue and for green.
// ============================================================================
module agpc_scale
    import agpc_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_en,
    input  logic  i_valid,
    input  t_sel  i_sel,
    output logic  o_valid,
    output t_prod o_prod
);

    logic        r_valid;
    t_prod       r_prod;
    t_prod       n_prod;
    logic [31:0] rb_s;
    logic [31:0] rb_d;
    logic [31:0] g_s;
    logic [31:0] g_d;
    logic [31:0] rb_diff;
    logic [31:0] g_diff;
    logic [31:0] w32;
    logic [31:0] rb_mul;
    logic [31:0] g_mul;

    // Wrapping 32-bit packed difference and product; keep bits 27:4
    always_comb begin
        rb_s    = {8'd0, i_sel.c1 & RB_MASK};
        rb_d    = {8'd0, i_sel.c2 & RB_MASK};
        g_s     = {8'd0, i_sel.c1 & G_MASK};
        g_d     = {8'd0, i_sel.c2 & G_MASK};
        rb_diff = rb_s - rb_d;
        g_diff  = g_s - g_d;
        w32     = {{(32-WEIGHT_W){1'b0}}, i_sel.w};
        rb_mul  = rb_diff * w32;
        g_mul   = g_diff * w32;

        n_prod.rb_term = rb_mul[27:4];
        n_prod.g_term  = g_mul[27:4];
        n_prod.rb_base = rb_d[PIX_W-1:0];
        n_prod.g_base  = g_d[PIX_W-1:0];
        n_prod.px      = i_sel.px;
        n_prod.bypass  = i_sel.bypass;
    end

    // Advance stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Hold payload unless advancing
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;

endmodule

[sv/agpc_merge.sv]
// ============================================================================
// agpc_merge
// Stage 3: add base terms, mask channels and register the output pixel.
// ============================================================================
module agpc_merge
    import agpc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  t_prod            i_prod,
    output logic             o_valid,
    output logic [PIX_W-1:0] o_pixel
);

    logic             r_valid;
    logic [PIX_W-1:0] r_pixel;
    logic [PIX_W-1:0] n_pixel;
    logic [PIX_W-1:0] rb_sum;
    logic [PIX_W-1:0] g_sum;

    // Combine channels, or pass the frame pixel through
    always_comb begin
        rb_sum  = i_prod.rb_base + i_prod.rb_term;
        g_sum   = i_prod.g_base + i_prod.g_term;
        n_pixel = i_prod.bypass ? i_prod.px : ((rb_sum & RB_MASK) | (g_sum & G_MASK));
    end

    // Advance output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // Hold output beat unless advancing
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_valid = r_valid;
    assign o_pixel = r_pixel;

endmodule

[bench/agpc_checker.sv]
`timescale 1ns / 100ps
// ============================================================================
// agpc_checker
// Watches the pixel channels and the register port of the compositor, works
// out each blended pixel on its own and compares it with the output beats.
// ============================================================================
module agpc_checker
    import agpc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [PIX_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [ALPHA_W-1:0]   i_alpha,
    input  logic [PIX_W-1:0]     i_frame_pixel,
    input  logic [PIX_W-1:0]     i_backdrop_pixel,
    input  logic [PIX_W-1:0]     i_image_pixel,
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [PIX_W-1:0]     i_new_pixel,
    output int                   o_fail_count,
    output int                   o_pending,
    output int                   o_checked
);

    localparam int MAX_REPORTS = 20;

    // Register copy and the pixels still owed by the block
    t_cfg             regs;
    logic [PIX_W-1:0] owed_pixels[$];
    int               fails = 0;
    int               checked = 0;

    // Mix two packed colors with the widened weight, 32-bit wrapping math
    function automatic logic [PIX_W-1:0] blend(logic [PIX_W-1:0] c1, logic [PIX_W-1:0] c2,
                                               logic [ALPHA_W-1:0] a);
        logic [31:0] w;
        logic [31:0] s;
        logic [31:0] d;
        logic [31:0] rb;
        logic [31:0] g;
        w  = 32'(a) + (32'(a) >> 3);
        s  = 32'(c1 & RB_MASK);
        d  = 32'(c2 & RB_MASK);
        rb = (d + (((s - d) * w) >> 4)) & 32'(RB_MASK);
        s  = 32'(c1 & G_MASK);
        d  = 32'(c2 & G_MASK);
        g  = (d + (((s - d) * w) >> 4)) & 32'(G_MASK);
        return rb[PIX_W-1:0] | g[PIX_W-1:0];
    endfunction

    // Pick the two colors for the current mode and blend them
    function automatic logic [PIX_W-1:0] composite(t_cfg c, logic [ALPHA_W-1:0] a,
                                                   logic [PIX_W-1:0] frame,
                                                   logic [PIX_W-1:0] backdrop,
                                                   logic [PIX_W-1:0] image);
        logic [ALPHA_W-1:0] k;
        logic [PIX_W-1:0]   back_src;
        logic [PIX_W-1:0]   fore_src;
        logic [PIX_W-1:0]   result;
        k = c.inverse_video ? ALPHA_MAX - a : a;
        // backdrop only reaches the modes that draw a background
        back_src = c.backdrop_enable ? backdrop : c.back_color;
        fore_src = c.image_enable ? image : c.fore_color;
        result   = frame;
        case (c.draw_mode)
            MODE_COMPLEMENT: begin
                if (!c.image_enable) result = blend(frame, ~frame, k);
            end
            MODE_BACK: begin
                if (!c.image_enable) result = blend(back_src, frame, k);
            end
            MODE_FORE: begin
                result = blend(frame, fore_src, k);
            end
            default: begin
                result = blend(back_src, fore_src, k);
            end
        endcase
        return result;
    endfunction

    // Retire output beats first, then queue the pixel taken at this edge
    always @(posedge i_clk) begin : watch_blk
        logic [PIX_W-1:0] want;
        if (!i_rst_n) begin
            regs.draw_mode       = MODE_SOLID;
            regs.inverse_video   = 1'b0;
            regs.backdrop_enable = 1'b0;
            regs.image_enable    = 1'b0;
            regs.fore_color      = '0;
            regs.back_color      = '1;
            owed_pixels.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                checked++;
                if (owed_pixels.size() == 0) begin
                    fails++;
                    if (fails <= MAX_REPORTS)
                        $display("%0t: unexpected pixel beat: expected none, actual %06h",
                                 $time, i_new_pixel);
                end else begin
                    want = owed_pixels.pop_front();
                    if (want !== i_new_pixel) begin
                        fails++;
                        if (fails <= MAX_REPORTS)
                            $display("%0t: new_pixel mismatch: expected %06h, actual %06h",
                                     $time, want, i_new_pixel);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                owed_pixels.push_back(composite(regs, i_alpha, i_frame_pixel,
                                                i_backdrop_pixel, i_image_pixel));
            // track register writes; spare indexes change nothing
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DRAW_MODE:       regs.draw_mode       = t_mode'(i_cfg_data[1:0]);
                    CFG_INVERSE_VIDEO:   regs.inverse_video   = i_cfg_data[0];
                    CFG_BACKDROP_ENABLE: regs.backdrop_enable = i_cfg_data[0];
                    CFG_IMAGE_ENABLE:    regs.image_enable    = i_cfg_data[0];
                    CFG_FORE_COLOR:      regs.fore_color      = i_cfg_data;
                    CFG_BACK_COLOR:      regs.back_color      = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_fail_count <= fails;
        o_pending    <= owed_pixels.size();
        o_checked    <= checked;
    end

endmodule

[bench/tb_alpha_glyph_pixel_compositor.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_alpha_glyph_pixel_compositor
// Drives pixels and register settings into the compositor: a directed set
// of weights and extreme pixels, then every combination of draw mode,
// inversion, backdrop and image with random pixels and random idling on
// both channels. The checker beside the block predicts and compares.
// ============================================================================
module tb_alpha_glyph_pixel_compositor;
    import agpc_pkg::*;

    localparam int                   CLK_HALF     = 4;
    localparam int                   RESET_CYCLES = 8;
    localparam int                   SETTINGS_N   = 32;
    localparam int                   PHASE_PIXELS = 28;
    localparam int                   HOLD_CYCLES  = 64;
    localparam int                   SETTLE       = 10;
    localparam int                   CYCLE_LIMIT  = 200000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [PIX_W-1:0]     i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    logic [ALPHA_W-1:0]   i_alpha;
    logic [PIX_W-1:0]     i_frame_pixel;
    logic [PIX_W-1:0]     i_backdrop_pixel;
    logic [PIX_W-1:0]     i_image_pixel;
    logic                 o_valid;
    logic                 i_stall;
    logic [PIX_W-1:0]     o_new_pixel;

    int fail_count;
    int pending;
    int checked;
    int pixels_sent;
    int out_gap;
    bit tx_quiet;
    bit rx_quiet;
    bit hold_req;

    alpha_glyph_pixel_compositor DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_alpha          (i_alpha),
        .i_frame_pixel    (i_frame_pixel),
        .i_backdrop_pixel (i_backdrop_pixel),
        .i_image_pixel    (i_image_pixel),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_new_pixel      (o_new_pixel)
    );

    agpc_checker u_checker (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_valid),
        .i_in_stall       (o_stall),
        .i_alpha          (i_alpha),
        .i_frame_pixel    (i_frame_pixel),
        .i_backdrop_pixel (i_backdrop_pixel),
        .i_image_pixel    (i_image_pixel),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_new_pixel      (o_new_pixel),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_checked        (checked)
    );

    // Clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Abort a hung run
    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("FAIL alpha_glyph_pixel_compositor");
        $finish;
    end

    // Output side: random stall after each beat, or one long hold on request
    initial begin : receiver
        i_stall = 1'b0;
        out_gap = 0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
                out_gap  = 0;
                i_stall <= 1'b0;
            end else begin
                if (o_valid && !i_stall)
                    out_gap = rx_quiet ? 0 : $urandom_range(0, 7);
                else if (out_gap > 0)
                    out_gap--;
                i_stall <= (out_gap > 0);
            end
        end
    end

    // Alpha with the extremes drawn often
    function automatic logic [ALPHA_W-1:0] rand_alpha();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALPHA_MAX;
            default: return ALPHA_W'($urandom_range(0, 15));
        endcase
    endfunction

    // Pixel with black and white drawn often
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom());
        endcase
    endfunction

    // Register value with random junk above its width
    function automatic logic [PIX_W-1:0] with_junk(logic [PIX_W-1:0] value, int bits);
        logic [PIX_W-1:0] mask;
        logic [PIX_W-1:0] junk;
        mask = (PIX_W'(1) << bits) - 1'b1;
        junk = PIX_W'($urandom());
        return (junk & ~mask) | (value & mask);
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [PIX_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Offer one pixel after a random gap and hold it until taken
    task automatic send_pixel(logic [ALPHA_W-1:0] alpha, logic [PIX_W-1:0] frame,
                              logic [PIX_W-1:0] backdrop, logic [PIX_W-1:0] image);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid          <= 1'b1;
        i_alpha          <= alpha;
        i_frame_pixel    <= frame;
        i_backdrop_pixel <= backdrop;
        i_image_pixel    <= image;
        do @(posedge i_clk); while (o_stall);
        pixels_sent++;
    endtask

    // Stop offering and wait until every owed pixel has come out
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // Load one register setting; the bits of sel pick mode and the flags
    task automatic program_setting(int sel);
        logic [PIX_W-1:0] fore;
        logic [PIX_W-1:0] back;
        case ((sel >> 1) % 3)
            0: begin
                fore = '0;
                back = '1;
            end
            1: begin
                fore = '1;
                back = '0;
            end
            default: begin
                fore = PIX_W'($urandom());
                back = PIX_W'($urandom());
            end
        endcase
        write_reg(CFG_DRAW_MODE, with_junk(PIX_W'(sel & 3), 2));
        write_reg(CFG_INVERSE_VIDEO, with_junk(PIX_W'((sel >> 2) & 1), 1));
        write_reg(CFG_BACKDROP_ENABLE, with_junk(PIX_W'((sel >> 3) & 1), 1));
        write_reg(CFG_IMAGE_ENABLE, with_junk(PIX_W'((sel >> 4) & 1), 1));
        write_reg(CFG_FORE_COLOR, fore);
        write_reg(CFG_BACK_COLOR, back);
        // spare indexes must leave the registers alone
        write_reg((sel & 1) ? CFG_SPARE_HI : CFG_SPARE_LO, PIX_W'($urandom()));
        i_cfg_we <= 1'b0;
    endtask

    // Stimulus and verdict
    initial begin : stimulus
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = '0;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_alpha          = '0;
        i_frame_pixel    = '0;
        i_backdrop_pixel = '0;
        i_image_pixel    = '0;
        tx_quiet         = 1'b0;
        rx_quiet         = 1'b0;
        hold_req         = 1'b0;
        pixels_sent      = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: every weight, then all-black, all-white and split-channel pixels
        for (int a = 0; a < 16; a++)
            send_pixel(ALPHA_W'(a), PIX_W'($urandom()), PIX_W'($urandom()),
                       PIX_W'($urandom()));
        send_pixel('0, '0, '0, '0);
        send_pixel(ALPHA_MAX, '1, '1, '1);
        send_pixel('0, '1, '1, '1);
        send_pixel(ALPHA_MAX, '0, '0, '0);
        send_pixel(4'd8, 24'h00ff00, 24'hff00ff, 24'h00ff00);
        drain();

        // Every mode and flag combination with random pixels
        for (int sel = 0; sel < SETTINGS_N; sel++) begin
            program_setting(sel);
            tx_quiet = (sel % 4 == 1);
            rx_quiet = (sel % 4 == 2);
            if (sel == 9) begin
                tx_quiet = 1'b1;
                hold_req = 1'b1;
            end
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                if (sel == 20 && n == PHASE_PIXELS / 2)
                    drain();
                send_pixel(rand_alpha(), rand_pixel(), rand_pixel(), rand_pixel());
            end
            drain();
        end

        repeat (SETTLE) @(posedge i_clk);
        $display("Sent %0d pixels over %0d register settings: all draw modes, inversion,",
                 pixels_sent, SETTINGS_N + 1);
        $display("backdrop and image on and off, one long output hold; %0d beats checked.",
                 checked);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS alpha_glyph_pixel_compositor");
        end else begin
            $display("FAIL alpha_glyph_pixel_compositor");
        end
        $finish;
    end

endmodule
